>>> design/lfsgd_pkg.sv
// Shared constants for the latent-factor SGD update core.
// No dependencies; used by latent_factor_sgd_update_core.
package lfsgd_pkg;

   // operation codes carried in the func field
   localparam logic [1:0] FUNC_LOAD_USER  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_MOVIE = 2'd1;
   localparam logic [1:0] FUNC_TRAIN      = 2'd2;
   localparam logic [1:0] FUNC_PREDICT    = 2'd3;

   // configuration register indexes
   localparam logic CSR_USER_RATE  = 1'b0;
   localparam logic CSR_MOVIE_RATE = 1'b1;

   // fixed field widths
   localparam int VAL_W   = 16;
   localparam int UIDX_W  = 10;
   localparam int MIDX_W  = 12;
   localparam int FIDX_W  = 5;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 32;
   localparam int SCALE_W = 33;  // rate * error, signed
   localparam int PROD_W  = 49;  // scale * element, signed

   // rounding constants
   localparam int DOT_SHIFT = 12;
   localparam int UPD_SHIFT = 28;

   typedef logic signed [VAL_W-1:0] val_type;

endpackage

>>> design/lfsgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on lfsgd_pkg only by convention (no package items used).
module lfsgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/latent_factor_sgd_update_core.sv
// Latent-factor SGD update core: user/movie feature tables, one shared MAC unit.
// Depends on lfsgd_pkg and lfsgd_ram.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata: func,user,movie,feature,load,rating
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: prediction, residual
//  csr     | in  | csr_wr_en              | csr_index, csr_wdata
//
// A train runs two dot products and two vector updates element by element on the
// one multiplier; a predict runs one dot product and a load writes one element.
// Reset is synchronous and clears control only; the tables are not cleared.
// A finished word waits in the output register while the next item is taken;
// the sequencer only stalls when that register is still full at completion.
module latent_factor_sgd_update_core #(
   parameter int NUM_USERS    = 1024,
   parameter int NUM_MOVIES   = 4096,
   parameter int NUM_FEATURES = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [1:0] func, [11:2] user_index, [23:12] movie_index, [28:24] feature_index,
   // [44:29] load_value, [60:45] rating, [63:61] zero
   input  logic [lfsgd_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] prediction, [31:16] residual
   output logic [lfsgd_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_wdata
);

   localparam int UDEPTH = NUM_USERS * NUM_FEATURES;
   localparam int MDEPTH = NUM_MOVIES * NUM_FEATURES;
   localparam int UAW    = $clog2(UDEPTH);
   localparam int MAW    = $clog2(MDEPTH);
   localparam int KW     = $clog2(NUM_FEATURES + 1);
   localparam int ACC_W  = 33 + $clog2(NUM_FEATURES + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_DOT1 = 4'd2;
   localparam logic [3:0] S_SCL1 = 4'd3;
   localparam logic [3:0] S_UPDU = 4'd4;
   localparam logic [3:0] S_DOT2 = 4'd5;
   localparam logic [3:0] S_SCL2 = 4'd6;
   localparam logic [3:0] S_UPDM = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   function automatic lfsgd_pkg::val_type sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // request fields
   logic [1:0]                      req_func;
   logic [lfsgd_pkg::UIDX_W-1:0]    req_user;
   logic [lfsgd_pkg::MIDX_W-1:0]    req_movie;
   logic [lfsgd_pkg::FIDX_W-1:0]    req_feat;
   assign req_func  = req_tdata[1:0];
   assign req_user  = req_tdata[11:2];
   assign req_movie = req_tdata[23:12];
   assign req_feat  = req_tdata[28:24];

   // control and payload registers
   logic [3:0]                state_ff, state_in;
   logic [15:0]               user_rate_ff, movie_rate_ff;
   logic [1:0]                func_ff;
   logic                      feat_ok_ff, user_ok_ff, movie_ok_ff;
   logic [UAW-1:0]            ubase_ff;
   logic [MAW-1:0]            mbase_ff;
   logic [lfsgd_pkg::FIDX_W-1:0] feat_ff;
   lfsgd_pkg::val_type        load_ff, rating_ff;
   lfsgd_pkg::val_type        pred_ff, resid_ff, err_ff;
   logic signed [lfsgd_pkg::SCALE_W-1:0] scale_ff;
   logic [KW-1:0]             issue_k_ff;
   logic                      s1_v_ff, s2_v_ff;
   logic [KW-1:0]             s1_k_ff, s2_k_ff;
   logic signed [lfsgd_pkg::PROD_W-1:0] p_ff;
   lfsgd_pkg::val_type        tgt_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      rsp_v_ff;
   logic [lfsgd_pkg::RSP_W-1:0] rsp_data_ff;

   // memories
   logic               u_we, m_we;
   logic [UAW-1:0]     u_waddr;
   logic [MAW-1:0]     m_waddr;
   logic [15:0]        u_wdata, m_wdata, u_rd, m_rd;
   logic [UAW-1:0]     u_raddr;
   logic [MAW-1:0]     m_raddr;

   lfsgd_ram #(.WIDTH(16), .DEPTH(UDEPTH)) u_user_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_waddr), .wr_data(u_wdata),
      .rd_addr(u_raddr), .rd_data(u_rd)
   );

   lfsgd_ram #(.WIDTH(16), .DEPTH(MDEPTH)) u_movie_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rd)
   );

   // phase decode
   logic in_dot, in_upd, in_stream, issuing, drained, accept, out_free;
   assign in_dot    = (state_ff == S_DOT1) || (state_ff == S_DOT2);
   assign in_upd    = (state_ff == S_UPDU) || (state_ff == S_UPDM);
   assign in_stream = in_dot || in_upd;
   assign issuing   = in_stream && (issue_k_ff < KW'(NUM_FEATURES));
   assign drained   = !issuing && !s1_v_ff && !s2_v_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_v_ff || rsp_tready;

   assign u_raddr = ubase_ff + UAW'(issue_k_ff);
   assign m_raddr = mbase_ff + MAW'(issue_k_ff);

   // shared multiplier with operand select
   logic signed [lfsgd_pkg::SCALE_W-1:0] mul_a;
   logic signed [15:0]                   mul_b;
   logic signed [lfsgd_pkg::PROD_W-1:0]  mul_p;
   lfsgd_pkg::val_type                   tgt_sel;
   always_comb begin
      mul_a   = lfsgd_pkg::SCALE_W'(signed'(u_rd));
      mul_b   = signed'(m_rd);
      tgt_sel = signed'(u_rd);
      unique case (state_ff)
         S_SCL1: begin
            mul_a = signed'({17'd0, user_rate_ff});
            mul_b = err_ff;
         end
         S_SCL2: begin
            mul_a = signed'({17'd0, movie_rate_ff});
            mul_b = err_ff;
         end
         S_UPDU: begin
            mul_a = scale_ff;
            mul_b = signed'(m_rd);
         end
         S_UPDM: begin
            mul_a   = scale_ff;
            mul_b   = signed'(u_rd);
            tgt_sel = signed'(m_rd);
         end
         default: begin
            mul_a = lfsgd_pkg::SCALE_W'(signed'(u_rd));
            mul_b = signed'(m_rd);
         end
      endcase
      mul_p = lfsgd_pkg::PROD_W'(mul_a) * lfsgd_pkg::PROD_W'(mul_b);
   end

   // update element: round delta, add, saturate
   logic signed [lfsgd_pkg::PROD_W-1:0] upd_sum;
   logic signed [lfsgd_pkg::PROD_W-1:0] upd_delta;
   lfsgd_pkg::val_type                  upd_val;
   assign upd_sum   = p_ff + (lfsgd_pkg::PROD_W'(1) <<< (lfsgd_pkg::UPD_SHIFT - 1));
   assign upd_delta = upd_sum >>> lfsgd_pkg::UPD_SHIFT;
   assign upd_val   = sat16(64'(upd_delta) + 64'(tgt_ff));

   // rounded dot product and error
   logic signed [ACC_W-1:0] dot_sum, dot_val;
   lfsgd_pkg::val_type      dot_sat, dot_err;
   assign dot_sum = acc_ff + ACC_W'(2048);
   assign dot_val = dot_sum >>> lfsgd_pkg::DOT_SHIFT;
   assign dot_sat = sat16(64'(dot_val));
   assign dot_err = sat16(64'(rating_ff) - 64'(dot_val));

   // write ports
   always_comb begin
      u_we    = 1'b0;
      m_we    = 1'b0;
      u_waddr = ubase_ff + UAW'(s2_k_ff);
      m_waddr = mbase_ff + MAW'(s2_k_ff);
      u_wdata = upd_val;
      m_wdata = upd_val;
      if (state_ff == S_LOAD) begin
         u_waddr = ubase_ff + UAW'(feat_ff);
         m_waddr = mbase_ff + MAW'(feat_ff);
         u_wdata = load_ff;
         m_wdata = load_ff;
         u_we = (func_ff == lfsgd_pkg::FUNC_LOAD_USER) && user_ok_ff && feat_ok_ff;
         m_we = (func_ff == lfsgd_pkg::FUNC_LOAD_MOVIE) && movie_ok_ff && feat_ok_ff;
      end else begin
         u_we = (state_ff == S_UPDU) && s2_v_ff;
         m_we = (state_ff == S_UPDM) && s2_v_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == lfsgd_pkg::FUNC_LOAD_USER ||
                   req_func == lfsgd_pkg::FUNC_LOAD_MOVIE) begin
                  state_in = S_LOAD;
               end else if (32'(req_user) < NUM_USERS && 32'(req_movie) < NUM_MOVIES) begin
                  state_in = S_DOT1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_LOAD: state_in = S_DONE;
         S_DOT1: begin
            if (drained) begin
               state_in = (func_ff == lfsgd_pkg::FUNC_TRAIN) ? S_SCL1 : S_DONE;
            end
         end
         S_SCL1: state_in = S_UPDU;
         S_UPDU: if (drained) state_in = S_DOT2;
         S_DOT2: if (drained) state_in = S_SCL2;
         S_SCL2: state_in = S_UPDM;
         S_UPDM: if (drained) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         user_rate_ff  <= 16'd655;
         movie_rate_ff <= 16'd655;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
         issue_k_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            if (csr_index == lfsgd_pkg::CSR_USER_RATE) begin
               user_rate_ff <= csr_wdata;
            end else begin
               movie_rate_ff <= csr_wdata;
            end
         end
         // element pipeline: issue, read data, product
         s1_v_ff <= issuing;
         s2_v_ff <= s1_v_ff;
         if (issuing) begin
            issue_k_ff <= issue_k_ff + KW'(1);
         end else if (!in_stream || drained) begin
            issue_k_ff <= '0;
         end
         // output word: set at completion, held until taken
         rsp_v_ff <= (state_ff == S_DONE && out_free) || (rsp_v_ff && !rsp_tready);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_k_ff <= issue_k_ff;
      s2_k_ff <= s1_k_ff;
      p_ff    <= mul_p;
      tgt_ff  <= tgt_sel;
      if (accept) begin
         func_ff     <= req_func;
         feat_ff     <= req_feat;
         load_ff     <= signed'(req_tdata[44:29]);
         rating_ff   <= signed'(req_tdata[60:45]);
         user_ok_ff  <= 32'(req_user) < NUM_USERS;
         movie_ok_ff <= 32'(req_movie) < NUM_MOVIES;
         feat_ok_ff  <= 32'(req_feat) < NUM_FEATURES;
         ubase_ff    <= UAW'(32'(req_user) * NUM_FEATURES);
         mbase_ff    <= MAW'(32'(req_movie) * NUM_FEATURES);
         pred_ff     <= '0;
         resid_ff    <= '0;
      end
      // accumulator cleared at the start of each dot pass
      if (state_ff == S_IDLE || state_ff == S_UPDU) begin
         acc_ff <= '0;
      end else if (in_dot && s2_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(p_ff);
      end
      if (state_ff == S_DOT1 && drained) begin
         pred_ff <= dot_sat;
         err_ff  <= dot_err;
         if (func_ff == lfsgd_pkg::FUNC_TRAIN) begin
            resid_ff <= dot_err;
         end
      end
      if (state_ff == S_DOT2 && drained) begin
         err_ff <= dot_err;
      end
      if (state_ff == S_SCL1 || state_ff == S_SCL2) begin
         scale_ff <= lfsgd_pkg::SCALE_W'(mul_p);
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_data_ff <= {resid_ff, pred_ff};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
